/* hw/rtl/rci_pkg.sv */
// shared types, constants and saturating helpers for the ray/cone intersection block
// used by every rtl file of the block but rci_delay; depends on nothing
`timescale 1ns / 1ps

package rci_pkg;

  localparam int unsigned QW    = 48;  // working word, q16.16 in 48 bit signed
  localparam int unsigned MW    = 47;  // magnitude of a working word
  localparam int unsigned RW    = 63;  // sqrt radicand and divider numerator
  localparam int unsigned SQW   = 32;  // square root result
  localparam int unsigned PW    = 94;  // full magnitude product
  localparam int unsigned OW    = 32;  // output word
  localparam int unsigned CFGW  = 32;  // config data
  localparam int unsigned CFGIW = 3;   // config index

  typedef logic signed [QW-1:0] q48_t;

  localparam q48_t QLIM = 48'sh7FFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    OC_TWO_ROOTS  = 3'd0,
    OC_LINEAR     = 3'd1,
    OC_SMALL_DISC = 3'd2,
    OC_C_ZERO     = 3'd3,
    OC_DEGENERATE = 3'd4
  } outcome_e;

  typedef enum logic [CFGIW-1:0] {
    CFG_APEX_X  = 3'd0,
    CFG_APEX_Y  = 3'd1,
    CFG_APEX_Z  = 3'd2,
    CFG_AXIS_X  = 3'd3,
    CFG_AXIS_Y  = 3'd4,
    CFG_AXIS_Z  = 3'd5,
    CFG_SLANT   = 3'd6,
    CFG_EPSILON = 3'd7
  } cfg_idx_e;

  function automatic q48_t sat48(input logic signed [QW+1:0] v);
    q48_t r;
    if (v > 50'sh0_7FFF_FFFF_FFFF) begin
      r = QLIM;
    end else if (v < -50'sh0_7FFF_FFFF_FFFF) begin
      r = -QLIM;
    end else begin
      r = v[QW-1:0];
    end
    return r;
  endfunction

  function automatic q48_t add_sat(input q48_t a, input q48_t b);
    logic signed [QW+1:0] s;
    s = 50'(a) + 50'(b);
    return sat48(s);
  endfunction

  function automatic q48_t sub_sat(input q48_t a, input q48_t b);
    logic signed [QW+1:0] s;
    s = 50'(a) - 50'(b);
    return sat48(s);
  endfunction

  function automatic q48_t dbl_sat(input q48_t a);
    logic signed [QW+1:0] s;
    s = $signed({a[QW-1], a, 1'b0});
    return sat48(s);
  endfunction

  function automatic q48_t quad_sat(input q48_t a);
    logic signed [QW+1:0] s;
    s = $signed({a, 2'b00});
    return sat48(s);
  endfunction

  function automatic logic [MW-1:0] mag(input q48_t v);
    logic [QW-1:0] n;
    n = v[QW-1] ? QW'(-v) : QW'(v);
    return n[MW-1:0];
  endfunction

  function automatic logic near_zero(input q48_t v, input q48_t eps);
    logic [QW-1:0] m;
    m = {1'b0, mag(v)};
    return (v == '0) || (m < QW'(eps));
  endfunction

  function automatic logic signed [OW-1:0] out32(input q48_t v);
    logic signed [OW-1:0] r;
    if (v > 48'sh0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -48'sh0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[OW-1:0];
    end
    return r;
  endfunction

endpackage

/* hw/rtl/rci_delay.sv */
// shift line that carries side data alongside a pipeline section
// uses no package items
`timescale 1ns / 1ps

module rci_delay #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] sr_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        sr_q[i] <= '0;
      end
    end else begin
      sr_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        sr_q[i] <= sr_q[i-1];
      end
    end
  end

  assign q_o = sr_q[DEPTH-1];

endmodule

/* hw/rtl/rci_qmul.sv */
// two-stage saturating q16.16 multiplier on 48 bit words
// partial products of 24 and 23 bit halves, then sum, saturate and sign; uses rci_pkg
`timescale 1ns / 1ps

module rci_qmul (
  input  logic          clk_i,
  input  rci_pkg::q48_t a_i,
  input  rci_pkg::q48_t b_i,
  output rci_pkg::q48_t p_o
);

  logic [rci_pkg::MW-1:0] ma, mb;
  logic [47:0] ll_d, lh_d, hl_d, hh_d;
  logic [47:0] ll_q, lh_q, hl_q, hh_q;
  logic        neg_q;
  logic [rci_pkg::PW-1:0] prod;
  logic        sat;
  rci_pkg::q48_t m, p_d, p_q;

  always_comb begin
    ma   = rci_pkg::mag(a_i);
    mb   = rci_pkg::mag(b_i);
    ll_d = 48'(ma[23:0]) * 48'(mb[23:0]);
    lh_d = 48'(ma[23:0]) * 48'(mb[46:24]);
    hl_d = 48'(ma[46:24]) * 48'(mb[23:0]);
    hh_d = 48'(ma[46:24]) * 48'(mb[46:24]);
  end

  always_ff @(posedge clk_i) begin
    ll_q  <= ll_d;
    lh_q  <= lh_d;
    hl_q  <= hl_d;
    hh_q  <= hh_d;
    neg_q <= a_i[rci_pkg::QW-1] ^ b_i[rci_pkg::QW-1];
  end

  always_comb begin
    prod = rci_pkg::PW'(ll_q) + (rci_pkg::PW'(lh_q) << 24) + (rci_pkg::PW'(hl_q) << 24)
         + (rci_pkg::PW'(hh_q) << 48);
    sat  = |prod[rci_pkg::PW-1:63];
    m    = sat ? rci_pkg::QLIM : $signed({1'b0, prod[62:16]});
    p_d  = neg_q ? -m : m;
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

/* hw/rtl/rci_sqrt_cell.sv */
// one cell of the square root chain: settles one root bit per cell
// uses rci_pkg widths
`timescale 1ns / 1ps

module rci_sqrt_cell #(
  parameter int unsigned BIT = 0
) (
  input  logic                    clk_i,
  input  logic [rci_pkg::RW-1:0]  rem_i,
  input  logic [rci_pkg::SQW-1:0] root_i,
  output logic [rci_pkg::RW-1:0]  rem_o,
  output logic [rci_pkg::SQW-1:0] root_o
);

  logic [rci_pkg::RW+1:0]  trial, diff;
  logic                    ge;
  logic [rci_pkg::RW-1:0]  rem_d, rem_q;
  logic [rci_pkg::SQW-1:0] root_d, root_q;

  always_comb begin
    trial  = ((rci_pkg::RW+2)'(root_i) << (BIT + 1)) + ((rci_pkg::RW+2)'(1) << (2 * BIT));
    ge     = (rci_pkg::RW+2)'(rem_i) >= trial;
    diff   = (rci_pkg::RW+2)'(rem_i) - trial;
    rem_d  = ge ? diff[rci_pkg::RW-1:0] : rem_i;
    root_d = ge ? (root_i | (rci_pkg::SQW'(1) << BIT)) : root_i;
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule

/* hw/rtl/rci_div_cell.sv */
// one cell of a restoring divider chain: settles one quotient bit per cell
// uses rci_pkg widths
`timescale 1ns / 1ps

module rci_div_cell #(
  parameter int unsigned BIT = 0
) (
  input  logic                   clk_i,
  input  logic [rci_pkg::RW-1:0] rem_i,
  input  logic [rci_pkg::MW-1:0] den_i,
  input  logic [rci_pkg::MW-1:0] q_i,
  output logic [rci_pkg::RW-1:0] rem_o,
  output logic [rci_pkg::MW-1:0] den_o,
  output logic [rci_pkg::MW-1:0] q_o
);

  logic [rci_pkg::PW-1:0] trial, diff;
  logic                   ge;
  logic [rci_pkg::RW-1:0] rem_d, rem_q;
  logic [rci_pkg::MW-1:0] q_d, q_q, den_q;

  always_comb begin
    trial = rci_pkg::PW'(den_i) << BIT;
    ge    = rci_pkg::PW'(rem_i) >= trial;
    diff  = rci_pkg::PW'(rem_i) - trial;
    rem_d = ge ? diff[rci_pkg::RW-1:0] : rem_i;
    q_d   = ge ? (q_i | (rci_pkg::MW'(1) << BIT)) : q_i;
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    q_q   <= q_d;
    den_q <= den_i;
  end

  assign rem_o = rem_q;
  assign den_o = den_q;
  assign q_o   = q_q;

endmodule

/* hw/rtl/ray_cone_intersection.sv */
// Ray against infinite double cone, q16.16. One item per clock, busy_o stays low, so start_i
// may be high in every cycle. Each result shows on the output ports with done_o for exactly one
// cycle; the receiver cannot stall and must take it.
// The pipeline holds the 32-cell square root chain and the two 47-cell divider chains.
// Configuration may be written only while no item is in flight.
// top level; uses rci_pkg, rci_qmul, rci_sqrt_cell, rci_div_cell, rci_delay
`timescale 1ns / 1ps

module ray_cone_intersection (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic                       cfg_we_i,
  input  logic [rci_pkg::CFGIW-1:0]  cfg_idx_i,
  input  logic [rci_pkg::CFGW-1:0]   cfg_data_i,
  input  logic signed [31:0]         origin_x_i,
  input  logic signed [31:0]         origin_y_i,
  input  logic signed [31:0]         origin_z_i,
  input  logic signed [31:0]         dir_x_i,
  input  logic signed [31:0]         dir_y_i,
  input  logic signed [31:0]         dir_z_i,
  output logic                       done_o,
  output logic [2:0]                 outcome_o,
  output logic signed [31:0]         t_near_o,
  output logic signed [31:0]         t_far_o,
  output logic signed [31:0]         dir_dot_axis_o,
  output logic signed [31:0]         offset_dot_axis_o
);

  typedef rci_pkg::q48_t q48_t;

  typedef struct packed {
    q48_t ddn;
    q48_t ocn;
    q48_t dd;
    q48_t oo;
    q48_t dp;
  } dots_t;

  typedef struct packed {
    q48_t a;
    q48_t b;
    q48_t c;
    q48_t ddn;
    q48_t ocn;
  } coef_t;

  typedef struct packed {
    rci_pkg::outcome_e oc;
    q48_t negb;
    q48_t numlin;
    q48_t den;
    q48_t ddn;
    q48_t ocn;
  } root_side_t;

  typedef struct packed {
    logic neg0;
    logic neg1;
    logic sat0;
    logic sat1;
    rci_pkg::outcome_e oc;
    q48_t ddn;
    q48_t ocn;
  } div_side_t;

  localparam int unsigned LAT = 95;

  // config registers
  logic signed [31:0] apex_q [3];
  logic signed [17:0] axis_q [3];
  logic [30:0]        slant_q;
  logic [15:0]        eps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      apex_q[0] <= '0;
      apex_q[1] <= '0;
      apex_q[2] <= '0;
      axis_q[0] <= '0;
      axis_q[1] <= 18'sd65536;
      axis_q[2] <= '0;
      slant_q   <= 31'd65536;
      eps_q     <= 16'd66;
    end else if (cfg_we_i) begin
      unique case (rci_pkg::cfg_idx_e'(cfg_idx_i))
        rci_pkg::CFG_APEX_X:  apex_q[0] <= cfg_data_i;
        rci_pkg::CFG_APEX_Y:  apex_q[1] <= cfg_data_i;
        rci_pkg::CFG_APEX_Z:  apex_q[2] <= cfg_data_i;
        rci_pkg::CFG_AXIS_X:  axis_q[0] <= cfg_data_i[17:0];
        rci_pkg::CFG_AXIS_Y:  axis_q[1] <= cfg_data_i[17:0];
        rci_pkg::CFG_AXIS_Z:  axis_q[2] <= cfg_data_i[17:0];
        rci_pkg::CFG_SLANT:   slant_q   <= cfg_data_i[30:0];
        rci_pkg::CFG_EPSILON: eps_q     <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  rci_delay #(.WIDTH(1), .DEPTH(LAT)) u_valid (
    .clk_i, .rst_ni, .d_i(start_i), .q_o(done_o)
  );

  // stage 0: offsets and operands
  logic signed [31:0] org [3];
  logic signed [31:0] dir [3];
  q48_t oc_q [3];
  q48_t d_q  [3];
  q48_t ax_q [3];

  assign org[0] = origin_x_i;
  assign org[1] = origin_y_i;
  assign org[2] = origin_z_i;
  assign dir[0] = dir_x_i;
  assign dir[1] = dir_y_i;
  assign dir[2] = dir_z_i;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      oc_q[i] <= 48'(org[i]) - 48'(apex_q[i]);
      d_q[i]  <= 48'(dir[i]);
      ax_q[i] <= 48'(axis_q[i]);
    end
  end

  // stage 2: products
  q48_t p_dax [3];
  q48_t p_oax [3];
  q48_t p_dd  [3];
  q48_t p_oo  [3];
  q48_t p_do  [3];
  q48_t p_ss;

  for (genvar i = 0; i < 3; i++) begin : g_dots
    rci_qmul u_dax (.clk_i, .a_i(d_q[i]),  .b_i(ax_q[i]), .p_o(p_dax[i]));
    rci_qmul u_oax (.clk_i, .a_i(oc_q[i]), .b_i(ax_q[i]), .p_o(p_oax[i]));
    rci_qmul u_dd  (.clk_i, .a_i(d_q[i]),  .b_i(d_q[i]),  .p_o(p_dd[i]));
    rci_qmul u_oo  (.clk_i, .a_i(oc_q[i]), .b_i(oc_q[i]), .p_o(p_oo[i]));
    rci_qmul u_do  (.clk_i, .a_i(d_q[i]),  .b_i(oc_q[i]), .p_o(p_do[i]));
  end

  rci_qmul u_ss (
    .clk_i, .a_i(q48_t'({17'd0, slant_q})), .b_i(q48_t'({17'd0, slant_q})), .p_o(p_ss)
  );

  // stage 3: dot products and k
  dots_t dots3_q;
  q48_t  k_q;

  always_ff @(posedge clk_i) begin
    dots3_q.ddn <= rci_pkg::add_sat(rci_pkg::add_sat(p_dax[0], p_dax[1]), p_dax[2]);
    dots3_q.ocn <= rci_pkg::add_sat(rci_pkg::add_sat(p_oax[0], p_oax[1]), p_oax[2]);
    dots3_q.dd  <= rci_pkg::add_sat(rci_pkg::add_sat(p_dd[0], p_dd[1]), p_dd[2]);
    dots3_q.oo  <= rci_pkg::add_sat(rci_pkg::add_sat(p_oo[0], p_oo[1]), p_oo[2]);
    dots3_q.dp  <= rci_pkg::add_sat(rci_pkg::add_sat(p_do[0], p_do[1]), p_do[2]);
    k_q         <= rci_pkg::add_sat(48'sd65536, p_ss);
  end

  // stage 5: k times axial parts
  q48_t  kd, ko;
  dots_t dots5, dots7;

  rci_qmul u_kd (.clk_i, .a_i(k_q), .b_i(dots3_q.ddn), .p_o(kd));
  rci_qmul u_ko (.clk_i, .a_i(k_q), .b_i(dots3_q.ocn), .p_o(ko));

  rci_delay #(.WIDTH($bits(dots_t)), .DEPTH(2)) u_dl5 (
    .clk_i, .rst_ni, .d_i(dots3_q), .q_o(dots5)
  );

  // stage 7: second products
  q48_t kdd, kdo, koo;

  rci_qmul u_kdd (.clk_i, .a_i(kd), .b_i(dots5.ddn), .p_o(kdd));
  rci_qmul u_kdo (.clk_i, .a_i(kd), .b_i(dots5.ocn), .p_o(kdo));
  rci_qmul u_koo (.clk_i, .a_i(ko), .b_i(dots5.ocn), .p_o(koo));

  rci_delay #(.WIDTH($bits(dots_t)), .DEPTH(2)) u_dl7 (
    .clk_i, .rst_ni, .d_i(dots5), .q_o(dots7)
  );

  // stage 8: coefficients
  coef_t coef8_q, coef10, coef11_q;

  always_ff @(posedge clk_i) begin
    coef8_q.a   <= rci_pkg::sub_sat(dots7.dd, kdd);
    coef8_q.c   <= rci_pkg::sub_sat(dots7.oo, koo);
    coef8_q.b   <= rci_pkg::dbl_sat(rci_pkg::sub_sat(dots7.dp, kdo));
    coef8_q.ddn <= dots7.ddn;
    coef8_q.ocn <= dots7.ocn;
  end

  // stage 10: b^2 and a*c
  q48_t bb, ac;

  rci_qmul u_bb (.clk_i, .a_i(coef8_q.b), .b_i(coef8_q.b), .p_o(bb));
  rci_qmul u_ac (.clk_i, .a_i(coef8_q.a), .b_i(coef8_q.c), .p_o(ac));

  rci_delay #(.WIDTH($bits(coef_t)), .DEPTH(2)) u_dl10 (
    .clk_i, .rst_ni, .d_i(coef8_q), .q_o(coef10)
  );

  // stage 11: discriminant
  q48_t disc_q;

  always_ff @(posedge clk_i) begin
    disc_q   <= rci_pkg::sub_sat(bb, rci_pkg::quad_sat(ac));
    coef11_q <= coef10;
  end

  // stage 12: classify
  q48_t              eps48;
  rci_pkg::outcome_e oc_d;
  root_side_t        rs12_q, rs44;
  logic [rci_pkg::RW-1:0] rad_d, rad12_q;

  assign eps48 = q48_t'({32'd0, eps_q});

  always_comb begin
    if (disc_q < eps48) begin
      oc_d = rci_pkg::OC_SMALL_DISC;
    end else if (rci_pkg::near_zero(coef11_q.c, eps48)) begin
      oc_d = rci_pkg::OC_C_ZERO;
    end else if (rci_pkg::near_zero(coef11_q.a, eps48)) begin
      oc_d = rci_pkg::near_zero(coef11_q.b, eps48) ? rci_pkg::OC_DEGENERATE
                                                    : rci_pkg::OC_LINEAR;
    end else begin
      oc_d = rci_pkg::OC_TWO_ROOTS;
    end
    rad_d = disc_q[rci_pkg::QW-1] ? '0 : {disc_q[rci_pkg::MW-1:0], 16'd0};
  end

  always_ff @(posedge clk_i) begin
    rad12_q       <= rad_d;
    rs12_q.oc     <= oc_d;
    rs12_q.negb   <= -coef11_q.b;
    rs12_q.numlin <= -coef11_q.c;
    rs12_q.den    <= (oc_d == rci_pkg::OC_LINEAR) ? coef11_q.b : rci_pkg::dbl_sat(coef11_q.a);
    rs12_q.ddn    <= coef11_q.ddn;
    rs12_q.ocn    <= coef11_q.ocn;
  end

  // stages 13..44: square root chain
  logic [rci_pkg::RW-1:0]  srem  [rci_pkg::SQW+1];
  logic [rci_pkg::SQW-1:0] sroot [rci_pkg::SQW+1];

  assign srem[0]  = rad12_q;
  assign sroot[0] = '0;

  for (genvar j = 0; j < rci_pkg::SQW; j++) begin : g_sqrt
    rci_sqrt_cell #(.BIT(rci_pkg::SQW - 1 - j)) u_cell (
      .clk_i,
      .rem_i (srem[j]),
      .root_i(sroot[j]),
      .rem_o (srem[j+1]),
      .root_o(sroot[j+1])
    );
  end

  rci_delay #(.WIDTH($bits(root_side_t)), .DEPTH(rci_pkg::SQW)) u_dl44 (
    .clk_i, .rst_ni, .d_i(rs12_q), .q_o(rs44)
  );

  // stage 45: numerators
  q48_t              num0_q, num1_q, den45_q, ddn45_q, ocn45_q;
  rci_pkg::outcome_e oc45_q;
  q48_t              sq;

  assign sq = q48_t'({16'd0, sroot[rci_pkg::SQW]});

  always_ff @(posedge clk_i) begin
    if (rs44.oc == rci_pkg::OC_LINEAR) begin
      num0_q <= rs44.numlin;
      num1_q <= rs44.numlin;
    end else begin
      num0_q <= rci_pkg::sub_sat(rs44.negb, sq);
      num1_q <= rci_pkg::add_sat(rs44.negb, sq);
    end
    den45_q <= rs44.den;
    oc45_q  <= rs44.oc;
    ddn45_q <= rs44.ddn;
    ocn45_q <= rs44.ocn;
  end

  // stage 46: magnitudes and overflow check
  logic [rci_pkg::RW-1:0] ux0_d, ux1_d, ux0_q, ux1_q;
  logic [rci_pkg::MW-1:0] uy_d, uy_q;
  logic                   sat0_d, sat1_d;
  div_side_t              ds46_q, ds93;

  always_comb begin
    ux0_d  = {rci_pkg::mag(num0_q), 16'd0};
    ux1_d  = {rci_pkg::mag(num1_q), 16'd0};
    uy_d   = rci_pkg::mag(den45_q);
    sat0_d = {uy_d, 47'd0} <= rci_pkg::PW'(ux0_d);
    sat1_d = {uy_d, 47'd0} <= rci_pkg::PW'(ux1_d);
  end

  always_ff @(posedge clk_i) begin
    ux0_q       <= ux0_d;
    ux1_q       <= ux1_d;
    uy_q        <= uy_d;
    ds46_q.neg0 <= num0_q[rci_pkg::QW-1] ^ den45_q[rci_pkg::QW-1];
    ds46_q.neg1 <= num1_q[rci_pkg::QW-1] ^ den45_q[rci_pkg::QW-1];
    ds46_q.sat0 <= sat0_d;
    ds46_q.sat1 <= sat1_d;
    ds46_q.oc   <= oc45_q;
    ds46_q.ddn  <= ddn45_q;
    ds46_q.ocn  <= ocn45_q;
  end

  // stages 47..93: divider chains
  logic [rci_pkg::RW-1:0] r0 [rci_pkg::MW+1];
  logic [rci_pkg::RW-1:0] r1 [rci_pkg::MW+1];
  logic [rci_pkg::MW-1:0] y0 [rci_pkg::MW+1];
  logic [rci_pkg::MW-1:0] y1 [rci_pkg::MW+1];
  logic [rci_pkg::MW-1:0] qa [rci_pkg::MW+1];
  logic [rci_pkg::MW-1:0] qb [rci_pkg::MW+1];

  assign r0[0] = ux0_q;
  assign r1[0] = ux1_q;
  assign y0[0] = uy_q;
  assign y1[0] = uy_q;
  assign qa[0] = '0;
  assign qb[0] = '0;

  for (genvar j = 0; j < rci_pkg::MW; j++) begin : g_div
    rci_div_cell #(.BIT(rci_pkg::MW - 1 - j)) u_cell0 (
      .clk_i,
      .rem_i(r0[j]), .den_i(y0[j]), .q_i(qa[j]),
      .rem_o(r0[j+1]), .den_o(y0[j+1]), .q_o(qa[j+1])
    );
    rci_div_cell #(.BIT(rci_pkg::MW - 1 - j)) u_cell1 (
      .clk_i,
      .rem_i(r1[j]), .den_i(y1[j]), .q_i(qb[j]),
      .rem_o(r1[j+1]), .den_o(y1[j+1]), .q_o(qb[j+1])
    );
  end

  rci_delay #(.WIDTH($bits(div_side_t)), .DEPTH(rci_pkg::MW)) u_dl93 (
    .clk_i, .rst_ni, .d_i(ds46_q), .q_o(ds93)
  );

  // stage 94: sign, order, output saturation
  q48_t m0, m1, t0, t1, tn, tf;

  always_comb begin
    m0 = ds93.sat0 ? rci_pkg::QLIM : $signed({1'b0, qa[rci_pkg::MW]});
    m1 = ds93.sat1 ? rci_pkg::QLIM : $signed({1'b0, qb[rci_pkg::MW]});
    t0 = ds93.neg0 ? -m0 : m0;
    t1 = ds93.neg1 ? -m1 : m1;
    unique case (ds93.oc)
      rci_pkg::OC_TWO_ROOTS: begin
        tn = (t0 < t1) ? t0 : t1;
        tf = (t0 < t1) ? t1 : t0;
      end
      rci_pkg::OC_LINEAR: begin
        tn = t0;
        tf = t0;
      end
      default: begin
        tn = '0;
        tf = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    outcome_o         <= ds93.oc;
    t_near_o          <= rci_pkg::out32(tn);
    t_far_o           <= rci_pkg::out32(tf);
    dir_dot_axis_o    <= rci_pkg::out32(ds93.ddn);
    offset_dot_axis_o <= rci_pkg::out32(ds93.ocn);
  end

endmodule
